// ----- rtl/dprad_pkg.sv -----
// ----------------------------------------------------------------------------
// dprad_pkg
// Shared widths, codes and types of the DPCM/RLE audio decoder.
// ----------------------------------------------------------------------------
package dprad_pkg;

   localparam int SAMPLE_W = 8;
   localparam int COUNT_W  = 16;
   localparam int BLEN_W   = 8;
   localparam int CODE_W   = 8;
   localparam int BYTES_W  = 7;
   localparam int ROW_W    = 4;
   localparam int DIGIT_W  = 4;
   localparam int JOB_W    = 6;

   // Item kinds on the request channel.
   localparam logic REQ_START = 1'b0;
   localparam logic REQ_DATA  = 1'b1;

   // Block modes; command mode means no delta block is open.
   localparam logic [1:0] MODE_CMD  = 2'd0;
   localparam logic [1:0] MODE_ONE  = 2'd1;
   localparam logic [1:0] MODE_TWO  = 2'd2;
   localparam logic [1:0] MODE_FOUR = 2'd3;

   // Mode selector field of a block opening byte.
   localparam logic [1:0] SEL_ONE = 2'b01;
   localparam logic [1:0] SEL_TWO = 2'b10;

   // Kinds of output job run by the sequencer.
   localparam logic JOB_HOLD  = 1'b0;
   localparam logic JOB_DELTA = 1'b1;

   localparam logic [DIGIT_W-1:0] CODE_TWO_BASE = 4'd6;
   localparam logic [7:0]         STEP_MAX      = 8'd127;

   typedef struct packed {
      logic [1:0]         mode;
      logic [ROW_W-1:0]   row;
      logic [DIGIT_W-1:0] digit;
   } dprad_delta_ctl_type;

endpackage

// ----- rtl/dprad_req_if.sv -----
// ----------------------------------------------------------------------------
// dprad_req_if
// Request channel of the decoder: start items and compressed data bytes.
// ----------------------------------------------------------------------------
interface dprad_req_if;
   logic                           valid;
   logic                           ready;
   logic                           req_type;
   logic [dprad_pkg::SAMPLE_W-1:0] first_sample;
   logic [dprad_pkg::COUNT_W-1:0]  sample_count;
   logic [dprad_pkg::BLEN_W-1:0]   block_size;
   logic [dprad_pkg::CODE_W-1:0]   code_byte;

   modport source (
      output valid, req_type, first_sample, sample_count, block_size, code_byte,
      input  ready
   );
   modport sink (
      input  valid, req_type, first_sample, sample_count, block_size, code_byte,
      output ready
   );
endinterface

// ----- rtl/dprad_rsp_if.sv -----
// ----------------------------------------------------------------------------
// dprad_rsp_if
// Response channel of the decoder: one decoded sample per word.
// ----------------------------------------------------------------------------
interface dprad_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [dprad_pkg::SAMPLE_W-1:0] sample;
   logic                           last;

   modport source (output valid, sample, last, input ready);
   modport sink   (input valid, sample, last, output ready);
endinterface

// ----- rtl/dprad_delta.sv -----
// ----------------------------------------------------------------------------
// dprad_delta
// Applies one delta digit to the current sample, with clamping to 0..255.
// ----------------------------------------------------------------------------
module dprad_delta (
   input  dprad_pkg::dprad_delta_ctl_type   ctl,
   input  logic [dprad_pkg::SAMPLE_W-1:0]   cur_sample,
   output logic [dprad_pkg::SAMPLE_W-1:0]   next_sample
);

   logic [dprad_pkg::DIGIT_W-1:0] code;
   logic [dprad_pkg::DIGIT_W-1:0] factor;
   logic [4:0]                    mult;
   logic [8:0]                    prod;
   logic                          neg;
   logic [7:0]                    mag;
   logic [8:0]                    acc;

   always_comb begin
      if (ctl.mode == dprad_pkg::MODE_TWO) begin
         code = dprad_pkg::CODE_TWO_BASE + {2'b00, ctl.digit[3:2]};
      end else begin
         code = ctl.digit;
      end
      // Codes below eight step down, the rest step up.
      neg    = ~code[3];
      factor = neg ? (4'd8 - code) : (code - 4'd7);
      mult   = {1'b0, ctl.row} + 5'd1;
      prod   = {4'b0000, mult} * {5'b00000, factor};

      if (ctl.mode == dprad_pkg::MODE_ONE) begin
         neg = ~ctl.digit[3];
         mag = 8'd1;
      end else if (!neg && (prod > {1'b0, dprad_pkg::STEP_MAX})) begin
         mag = dprad_pkg::STEP_MAX;
      end else begin
         mag = prod[7:0];
      end

      if (neg) begin
         acc         = {1'b0, cur_sample} - {1'b0, mag};
         next_sample = acc[8] ? 8'h00 : acc[7:0];
      end else begin
         acc         = {1'b0, cur_sample} + {1'b0, mag};
         next_sample = acc[8] ? 8'hFF : acc[7:0];
      end
   end

endmodule

// ----- rtl/dpcm_rle_audio_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// dpcm_rle_audio_decoder_unit
// Decodes a chunk of 8-bit audio from literal, repeat and delta-block codes.
// ----------------------------------------------------------------------------
//  channel  | direction | word
//  ---------+-----------+------------------------------------------------------
//  req_ch   | in        | req_type, first_sample, sample_count, block_size,
//           |           | code_byte
//  rsp_ch   | out       | sample, last
//
//  A request word is taken when the sequencer is free; its samples then leave
//  one per cycle from the output register while the response is not stalled.
//  Delta bytes are consumed from a shift register one digit per sample. A
//  stalled response holds the sequencer. Reset is synchronous.
// ----------------------------------------------------------------------------
module dpcm_rle_audio_decoder_unit (
   input  logic           clock,
   input  logic           reset,
   dprad_req_if.sink      req_ch,
   dprad_rsp_if.source    rsp_ch
);

   logic [dprad_pkg::SAMPLE_W-1:0] cur_ff, cur_in;
   logic [dprad_pkg::COUNT_W-1:0]  left_ff, left_in;
   logic [1:0]                     mode_ff, mode_in;
   logic [dprad_pkg::ROW_W-1:0]    row_ff, row_in;
   logic [dprad_pkg::BYTES_W-1:0]  bl_ff, bl_in;
   logic [dprad_pkg::BLEN_W-1:0]   blen_ff, blen_in;
   logic                           active_ff, active_in;
   logic                           busy_ff, busy_in;
   logic                           job_ff, job_in;
   logic [dprad_pkg::JOB_W-1:0]    cnt_ff, cnt_in;
   logic [dprad_pkg::CODE_W-1:0]   sr_ff, sr_in;
   logic                           out_valid_ff, out_valid_in;
   logic [dprad_pkg::SAMPLE_W-1:0] out_sample_ff, out_sample_in;
   logic                           out_last_ff, out_last_in;

   logic                           accept;
   logic                           emit;
   logic                           fin;
   logic [dprad_pkg::COUNT_W-1:0]  left_dec;
   logic [dprad_pkg::BYTES_W-1:0]  bl_dec;
   logic [dprad_pkg::BYTES_W-1:0]  open_bytes;
   logic [1:0]                     open_mode;
   logic [dprad_pkg::SAMPLE_W-1:0] delta_sample;
   logic [dprad_pkg::SAMPLE_W-1:0] emit_sample;
   dprad_pkg::dprad_delta_ctl_type delta_ctl;

   assign req_ch.ready = ~busy_ff;
   assign accept       = req_ch.valid & ~busy_ff;
   assign emit         = busy_ff & (~out_valid_ff | rsp_ch.ready);

   assign rsp_ch.valid  = out_valid_ff;
   assign rsp_ch.sample = out_sample_ff;
   assign rsp_ch.last   = out_last_ff;

   assign delta_ctl.mode  = mode_ff;
   assign delta_ctl.row   = row_ff;
   assign delta_ctl.digit = sr_ff[7:4];

   dprad_delta u_delta (
      .ctl         (delta_ctl),
      .cur_sample  (cur_ff),
      .next_sample (delta_sample)
   );

   assign left_dec    = left_ff - 16'd1;
   assign bl_dec      = bl_ff - 7'd1;
   assign fin         = (left_dec == '0);
   assign emit_sample = (job_ff == dprad_pkg::JOB_DELTA) ? delta_sample : cur_ff;

   // The block length comes from the start word of the chunk.
   always_comb begin
      case (req_ch.code_byte[5:4])
         dprad_pkg::SEL_ONE: begin
            open_mode  = dprad_pkg::MODE_ONE;
            open_bytes = {2'b00, blen_ff[7:3]};
         end
         dprad_pkg::SEL_TWO: begin
            open_mode  = dprad_pkg::MODE_TWO;
            open_bytes = {1'b0, blen_ff[7:2]};
         end
         default: begin
            open_mode  = dprad_pkg::MODE_FOUR;
            open_bytes = blen_ff[7:1];
         end
      endcase
   end

   always_comb begin
      cur_in        = cur_ff;
      left_in       = left_ff;
      mode_in       = mode_ff;
      row_in        = row_ff;
      bl_in         = bl_ff;
      blen_in       = blen_ff;
      active_in     = active_ff;
      busy_in       = busy_ff;
      job_in        = job_ff;
      cnt_in        = cnt_ff;
      sr_in         = sr_ff;
      out_valid_in  = out_valid_ff & ~rsp_ch.ready;
      out_sample_in = out_sample_ff;
      out_last_in   = out_last_ff;

      if (accept) begin
         if (req_ch.req_type == dprad_pkg::REQ_START) begin
            // A count of one or zero is held as one, so that the single
            // emitted sample carries the last flag and closes the chunk.
            cur_in    = req_ch.first_sample;
            blen_in   = req_ch.block_size;
            mode_in   = dprad_pkg::MODE_CMD;
            bl_in     = '0;
            row_in    = '0;
            left_in   = (req_ch.sample_count <= 16'd1) ? 16'd1 : req_ch.sample_count;
            active_in = 1'b1;
            busy_in   = 1'b1;
            job_in    = dprad_pkg::JOB_HOLD;
            cnt_in    = 6'd1;
         end else if (active_ff) begin
            if (mode_ff == dprad_pkg::MODE_CMD) begin
               if (req_ch.code_byte[7]) begin
                  cur_in  = {req_ch.code_byte[6:0], 1'b0};
                  busy_in = 1'b1;
                  job_in  = dprad_pkg::JOB_HOLD;
                  cnt_in  = 6'd1;
               end else if (req_ch.code_byte[6]) begin
                  busy_in = (req_ch.code_byte[5:0] != '0);
                  job_in  = dprad_pkg::JOB_HOLD;
                  cnt_in  = req_ch.code_byte[5:0];
               end else if (open_bytes != '0) begin
                  mode_in = open_mode;
                  row_in  = req_ch.code_byte[3:0];
                  bl_in   = open_bytes;
               end
            end else begin
               busy_in = 1'b1;
               job_in  = dprad_pkg::JOB_DELTA;
               sr_in   = req_ch.code_byte;
               case (mode_ff)
                  dprad_pkg::MODE_ONE: cnt_in = 6'd8;
                  dprad_pkg::MODE_TWO: cnt_in = 6'd4;
                  default:             cnt_in = 6'd2;
               endcase
            end
         end
      end

      if (emit) begin
         out_valid_in  = 1'b1;
         out_sample_in = emit_sample;
         out_last_in   = fin;
         cur_in        = emit_sample;
         left_in       = left_dec;
         cnt_in        = cnt_ff - 6'd1;
         case (mode_ff)
            dprad_pkg::MODE_ONE: sr_in = {sr_ff[6:0], 1'b0};
            dprad_pkg::MODE_TWO: sr_in = {sr_ff[5:0], 2'b00};
            default:             sr_in = {sr_ff[3:0], 4'b0000};
         endcase
         if (fin) begin
            busy_in   = 1'b0;
            active_in = 1'b0;
            mode_in   = dprad_pkg::MODE_CMD;
            bl_in     = '0;
         end else if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            // A delta byte that completes without ending the chunk uses up
            // one byte of the open block.
            if (job_ff == dprad_pkg::JOB_DELTA) begin
               bl_in = bl_dec;
               if (bl_dec == '0) begin
                  mode_in = dprad_pkg::MODE_CMD;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff       <= '0;
         left_ff      <= '0;
         mode_ff      <= dprad_pkg::MODE_CMD;
         row_ff       <= '0;
         bl_ff        <= '0;
         blen_ff      <= '0;
         active_ff    <= 1'b0;
         busy_ff      <= 1'b0;
         job_ff       <= dprad_pkg::JOB_HOLD;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_ff       <= cur_in;
         left_ff      <= left_in;
         mode_ff      <= mode_in;
         row_ff       <= row_in;
         bl_ff        <= bl_in;
         blen_ff      <= blen_in;
         active_ff    <= active_in;
         busy_ff      <= busy_in;
         job_ff       <= job_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sr_ff         <= sr_in;
      out_sample_ff <= out_sample_in;
      out_last_ff   <= out_last_in;
   end

`ifndef SYNTHESIS
   a_busy_has_work : assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cnt_ff != '0))
      else $error("sequencer busy with no samples left in its job");

   a_idle_in_cmd : assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> (mode_ff == dprad_pkg::MODE_CMD))
      else $error("delta block open while no chunk is active");

   a_block_has_bytes : assert property (@(posedge clock) disable iff (reset)
      (mode_ff != dprad_pkg::MODE_CMD) |-> (bl_ff != '0))
      else $error("delta block open with no bytes left");

   a_last_closes : assert property (@(posedge clock) disable iff (reset)
      (emit && fin) |=> (!active_ff && !busy_ff))
      else $error("chunk still running after its last sample");

   a_rsp_from_job : assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(busy_ff))
      else $error("response word raised without a running job");
`endif

endmodule

// ----- verif/tb_dpcm_rle_audio_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// tb_dpcm_rle_audio_decoder_unit
// Drives chunk start items and code bytes into the decoder and checks every
// decoded sample against hand-typed values or a cycle-free model, first from a
// short scripted sequence and then from random chunks under varying idling.
// ----------------------------------------------------------------------------
module tb_dpcm_rle_audio_decoder_unit;

   localparam int RAND_WORDS  = 350;
   localparam int LONG_HOLD   = 300;
   localparam int TAIL_CYCLES = 40;
   localparam int CYCLE_LIMIT = 600000;
   localparam int N_SCRIPT    = 24;
   localparam int PHASE_WORDS = 90;

   typedef enum int {PH_FREE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH} idle_phase_type;

   typedef struct packed {
      logic                           kind;
      logic [dprad_pkg::SAMPLE_W-1:0] first;
      logic [dprad_pkg::COUNT_W-1:0]  count;
      logic [dprad_pkg::BLEN_W-1:0]   bsize;
      logic [dprad_pkg::CODE_W-1:0]   code;
      bit                             typed;
      bit [1:0]                       n_typed;
      logic [dprad_pkg::SAMPLE_W-1:0] t_sample;
      logic                           t_last;
   } stim_row_type;

   typedef struct packed {
      logic [dprad_pkg::SAMPLE_W-1:0] sample;
      logic                           last;
   } sample_word_type;

   logic clock = 1'b0;
   logic reset;

   dprad_req_if req_ch ();
   dprad_rsp_if rsp_ch ();

   dpcm_rle_audio_decoder_unit uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Where a row is typed, its expected samples are written out by hand.
   stim_row_type script [N_SCRIPT] = '{
      //  kind                first  count      bsize  code   typed n     sample last
      '{dprad_pkg::REQ_DATA,  8'h00, 16'd0,     8'd0,   8'h85, 1'b1, 2'd0, 8'h00, 1'b0},
      '{dprad_pkg::REQ_START, 8'hFF, 16'd1,     8'd0,   8'h00, 1'b1, 2'd1, 8'hFF, 1'b1},
      '{dprad_pkg::REQ_START, 8'h00, 16'd0,     8'd255, 8'h00, 1'b1, 2'd1, 8'h00, 1'b1},
      '{dprad_pkg::REQ_DATA,  8'h00, 16'd0,     8'd0,   8'h81, 1'b1, 2'd0, 8'h00, 1'b0},
      '{dprad_pkg::REQ_START, 8'h80, 16'd65535, 8'd8,   8'h00, 1'b1, 2'd1, 8'h80, 1'b0},
      '{dprad_pkg::REQ_DATA,  8'h00, 16'd0,     8'd0,   8'hFF, 1'b1, 2'd1, 8'hFE, 1'b0},
      '{dprad_pkg::REQ_DATA,  8'h00, 16'd0,     8'd0,   8'h80, 1'b1, 2'd1, 8'h00, 1'b0},
      '{dprad_pkg::REQ_DATA,  8'h00, 16'd0,     8'd0,   8'h40, 1'b1, 2'd0, 8'h00, 1'b0},
      '{dprad_pkg::REQ_DATA,  8'h00, 16'd0,     8'd0,   8'h7F, 1'b0, 2'd0, 8'h00, 1'b0},
      '{dprad_pkg::REQ_DATA,  8'h00, 16'd0,     8'd0,   8'h10, 1'b1, 2'd0, 8'h00, 1'b0},
      '{dprad_pkg::REQ_DATA,  8'h00, 16'd0,     8'd0,   8'h00, 1'b0, 2'd0, 8'h00, 1'b0},
      '{dprad_pkg::REQ_DATA,  8'h00, 16'd0,     8'd0,   8'h2F, 1'b1, 2'd0, 8'h00, 1'b0},
      '{dprad_pkg::REQ_DATA,  8'h00, 16'd0,     8'd0,   8'hFF, 1'b0, 2'd0, 8'h00, 1'b0},
      '{dprad_pkg::REQ_DATA,  8'h00, 16'd0,     8'd0,   8'h00, 1'b0, 2'd0, 8'h00, 1'b0},
      '{dprad_pkg::REQ_DATA,  8'h00, 16'd0,     8'd0,   8'h3F, 1'b1, 2'd0, 8'h00, 1'b0},
      '{dprad_pkg::REQ_DATA,  8'h00, 16'd0,     8'd0,   8'hF0, 1'b0, 2'd0, 8'h00, 1'b0},
      '{dprad_pkg::REQ_DATA,  8'h00, 16'd0,     8'd0,   8'h0F, 1'b0, 2'd0, 8'h00, 1'b0},
      '{dprad_pkg::REQ_DATA,  8'h00, 16'd0,     8'd0,   8'h87, 1'b0, 2'd0, 8'h00, 1'b0},
      '{dprad_pkg::REQ_DATA,  8'h00, 16'd0,     8'd0,   8'hFF, 1'b0, 2'd0, 8'h00, 1'b0},
      '{dprad_pkg::REQ_DATA,  8'h00, 16'd0,     8'd0,   8'h05, 1'b1, 2'd0, 8'h00, 1'b0},
      '{dprad_pkg::REQ_START, 8'h7F, 16'd3,     8'd7,   8'h00, 1'b1, 2'd1, 8'h7F, 1'b0},
      '{dprad_pkg::REQ_DATA,  8'h00, 16'd0,     8'd0,   8'h10, 1'b1, 2'd0, 8'h00, 1'b0},
      '{dprad_pkg::REQ_DATA,  8'h00, 16'd0,     8'd0,   8'h45, 1'b0, 2'd0, 8'h00, 1'b0},
      '{dprad_pkg::REQ_DATA,  8'h00, 16'd0,     8'd0,   8'h81, 1'b1, 2'd0, 8'h00, 1'b0}
   };

   // Decoder state as the testbench sees it.
   logic [dprad_pkg::SAMPLE_W-1:0] dec_sample;
   logic [dprad_pkg::COUNT_W-1:0]  dec_left;
   logic [1:0]                     dec_mode;
   logic [dprad_pkg::ROW_W-1:0]    dec_row;
   logic [dprad_pkg::BYTES_W-1:0]  dec_bytes;
   logic [dprad_pkg::BLEN_W-1:0]   dec_blen;
   bit                             dec_active;

   sample_word_type fresh_samples[$];
   sample_word_type expected_samples[$];
   stim_row_type    chunk_q[$];
   stim_row_type    offered;

   idle_phase_type phase = PH_FREE;
   int             mismatches = 0;
   int             cycle_count = 0;
   bit             hold_armed;
   bit             hold_done = 1'b0;
   int             hold_left = 0;

   function automatic void emit_sample();
      bit fin;
      dec_left = dec_left - 1'b1;
      fin = (dec_left == '0);
      fresh_samples.push_back('{dec_sample, fin});
      if (fin) begin
         dec_active = 1'b0;
         dec_mode   = dprad_pkg::MODE_CMD;
         dec_bytes  = '0;
      end
   endfunction

   function automatic int step_of(input logic [dprad_pkg::DIGIT_W-1:0] code);
      int m;
      int v;
      m = int'(dec_row) + 1;
      if (code < 8)
         return -(m * (8 - int'(code)));
      v = m * (int'(code) - 7);
      return (v > int'(dprad_pkg::STEP_MAX)) ? int'(dprad_pkg::STEP_MAX) : v;
   endfunction

   function automatic void nudge_sample(input int d);
      int s;
      s = int'(dec_sample) + d;
      if (s < 0)
         s = 0;
      if (s > 255)
         s = 255;
      dec_sample = s[dprad_pkg::SAMPLE_W-1:0];
   endfunction

   // Works out the samples that one accepted word gives, into fresh_samples.
   function automatic void decode_word(input stim_row_type w);
      logic [dprad_pkg::CODE_W-1:0] b;
      logic [1:0]                   sel;
      logic [1:0]                   pick_mode;
      logic [dprad_pkg::BLEN_W-1:0] n_bytes;
      b = w.code;
      if (w.kind == dprad_pkg::REQ_START) begin
         dec_sample = w.first;
         dec_blen   = w.bsize;
         dec_mode   = dprad_pkg::MODE_CMD;
         dec_bytes  = '0;
         dec_row    = '0;
         if (w.count <= 1) begin
            dec_left   = '0;
            dec_active = 1'b0;
         end else begin
            dec_left   = w.count - 1'b1;
            dec_active = 1'b1;
         end
         fresh_samples.push_back('{dec_sample, !dec_active});
         return;
      end
      if (!dec_active)
         return;
      if (dec_mode == dprad_pkg::MODE_CMD) begin
         if (b[7]) begin
            dec_sample = {b[6:0], 1'b0};
            emit_sample();
         end else if (b[6]) begin
            for (int k = 0; k < int'(b[5:0]) && dec_active; k++)
               emit_sample();
         end else begin
            sel = b[5:4];
            if (sel == dprad_pkg::SEL_ONE) begin
               pick_mode = dprad_pkg::MODE_ONE;
               n_bytes   = dec_blen >> 3;
            end else if (sel == dprad_pkg::SEL_TWO) begin
               pick_mode = dprad_pkg::MODE_TWO;
               n_bytes   = dec_blen >> 2;
            end else begin
               pick_mode = dprad_pkg::MODE_FOUR;
               n_bytes   = dec_blen >> 1;
            end
            // A block too short to hold one byte leaves command mode in place.
            if (n_bytes != 0) begin
               dec_mode  = pick_mode;
               dec_row   = b[3:0];
               dec_bytes = n_bytes[dprad_pkg::BYTES_W-1:0];
            end
         end
         return;
      end
      if (dec_mode == dprad_pkg::MODE_ONE) begin
         for (int i = 0; i < 8 && dec_active; i++) begin
            nudge_sample(b[7-i] ? 1 : -1);
            emit_sample();
         end
      end else if (dec_mode == dprad_pkg::MODE_TWO) begin
         for (int i = 0; i < 4 && dec_active; i++) begin
            nudge_sample(step_of(dprad_pkg::CODE_TWO_BASE + b[7-2*i -: 2]));
            emit_sample();
         end
      end else begin
         for (int i = 0; i < 2 && dec_active; i++) begin
            nudge_sample(step_of(i == 0 ? b[7:4] : b[3:0]));
            emit_sample();
         end
      end
      if (dec_active) begin
         dec_bytes = dec_bytes - 1'b1;
         if (dec_bytes == '0)
            dec_mode = dprad_pkg::MODE_CMD;
      end
   endfunction

   function automatic stim_row_type data_row(input logic [dprad_pkg::CODE_W-1:0] code);
      stim_row_type r;
      r       = '0;
      r.kind  = dprad_pkg::REQ_DATA;
      r.code  = code;
      r.first = dprad_pkg::SAMPLE_W'($urandom);
      r.count = dprad_pkg::COUNT_W'($urandom);
      r.bsize = dprad_pkg::BLEN_W'($urandom);
      return r;
   endfunction

   // One random chunk: a start word, then mostly well-formed commands and
   // blocks, with some noise and blocks cut short.
   function automatic void plan_chunk();
      stim_row_type r;
      int           pick;
      int           n_bytes;
      logic [1:0]   sel;
      r      = data_row(dprad_pkg::CODE_W'($urandom));
      r.kind = dprad_pkg::REQ_START;
      pick   = $urandom_range(0, 99);
      if (pick < 6)
         r.count = dprad_pkg::COUNT_W'($urandom_range(0, 1));
      else if (pick < 14)
         r.count = dprad_pkg::COUNT_W'($urandom_range(0, 65535));
      else
         r.count = dprad_pkg::COUNT_W'($urandom_range(2, 300));
      pick = $urandom_range(0, 99);
      if (pick < 70)
         r.bsize = dprad_pkg::BLEN_W'(8 * $urandom_range(1, 4));
      else if (pick < 80)
         r.bsize = dprad_pkg::BLEN_W'($urandom_range(0, 255));
      else
         r.bsize = dprad_pkg::BLEN_W'($urandom_range(0, 15));
      chunk_q.push_back(r);
      repeat ($urandom_range(1, 10)) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            chunk_q.push_back(data_row(dprad_pkg::CODE_W'($urandom)));
         end else if (pick < 28) begin
            chunk_q.push_back(data_row({1'b1, 7'($urandom)}));
         end else if (pick < 45) begin
            chunk_q.push_back(data_row({2'b01, 6'($urandom)}));
         end else begin
            sel = 2'($urandom);
            chunk_q.push_back(data_row({2'b00, sel, 4'($urandom)}));
            if (sel == dprad_pkg::SEL_ONE)
               n_bytes = int'(r.bsize) >> 3;
            else if (sel == dprad_pkg::SEL_TWO)
               n_bytes = int'(r.bsize) >> 2;
            else
               n_bytes = int'(r.bsize) >> 1;
            if ($urandom_range(0, 9) == 0)
               n_bytes = $urandom_range(0, n_bytes);
            repeat (n_bytes) chunk_q.push_back(data_row(dprad_pkg::CODE_W'($urandom)));
         end
      end
   endfunction

   task automatic offer_word(input stim_row_type r);
      req_ch.valid        <= 1'b1;
      req_ch.req_type     <= r.kind;
      req_ch.first_sample <= r.first;
      req_ch.sample_count <= r.count;
      req_ch.block_size   <= r.bsize;
      req_ch.code_byte    <= r.code;
      offered             <= r;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if ($urandom_range(0, 99) < ((phase == PH_SEND_IDLE) ? 62 :
                                   (phase == PH_BOTH) ? 12 : 0)) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // Receiver: one long hold-off at the start of the random part, otherwise
   // stalls drawn per cycle according to the phase.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= hold_left - 1;
      end else if (hold_armed && !hold_done) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= LONG_HOLD;
         hold_done    <= 1'b1;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 99) >= ((phase == PH_RECV_STALL) ? 62 :
                                                    (phase == PH_BOTH) ? 12 : 0));
      end
   end

   always @(posedge clock) begin
      sample_word_type got;
      sample_word_type want;
      if (reset) begin
         dec_sample = '0;
         dec_left   = '0;
         dec_mode   = dprad_pkg::MODE_CMD;
         dec_row    = '0;
         dec_bytes  = '0;
         dec_blen   = '0;
         dec_active = 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            decode_word('{req_ch.req_type, req_ch.first_sample, req_ch.sample_count,
                          req_ch.block_size, req_ch.code_byte, 1'b0, 2'd0, 8'h00, 1'b0});
            if (offered.typed) begin
               if (offered.n_typed != 0)
                  expected_samples.push_back('{offered.t_sample, offered.t_last});
            end else begin
               foreach (fresh_samples[i]) expected_samples.push_back(fresh_samples[i]);
            end
            fresh_samples.delete();
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.sample, rsp_ch.last};
            if (expected_samples.size() == 0) begin
               $error("unexpected word: sample %0d, last %0d", got.sample, got.last);
               mismatches++;
            end else begin
               want = expected_samples.pop_front();
               if (got.sample !== want.sample) begin
                  $error("sample: expected %0d, got %0d", want.sample, got.sample);
                  mismatches++;
               end
               if (got.last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, got.last);
                  mismatches++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      int rand_sent;
      reset               <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.req_type     <= dprad_pkg::REQ_START;
      req_ch.first_sample <= '0;
      req_ch.sample_count <= '0;
      req_ch.block_size   <= '0;
      req_ch.code_byte    <= '0;
      hold_armed          <= 1'b0;
      offered             <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) offer_word(script[i]);

      // The receiver holds off first while words keep coming, so the block fills.
      hold_armed <= 1'b1;
      rand_sent = 0;
      while (rand_sent < RAND_WORDS) begin
         plan_chunk();
         while (chunk_q.size() != 0 && rand_sent < RAND_WORDS) begin
            phase = idle_phase_type'((rand_sent / PHASE_WORDS) % 4);
            offer_word(chunk_q.pop_front());
            rand_sent++;
         end
      end
      chunk_q.delete();
      req_ch.valid <= 1'b0;

      @(posedge clock);
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
